FILE: rtl/core/sbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch bank debounce scanner package
// Shared word types and fixed field widths of the debounce scanner.
// ----------------------------------------------------------------------------
package sbds_pkg;

    localparam int EXP_FIELD_W    = 16;
    localparam int GPIO_SWITCHES  = 2;
    localparam int TIME_W         = 63;
    localparam int SW_IDX_W       = 5;
    localparam int CFG_W          = 32;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 32'd30000000;

    typedef struct packed {
        logic [EXP_FIELD_W-1:0]   expander_word;
        logic [GPIO_SWITCHES-1:0] gpio_bits;
        logic [TIME_W-1:0]        now_time;
    } t_in_word;

    typedef struct packed {
        logic [SW_IDX_W-1:0] switch_index;
        logic                pressed;
        logic [TIME_W-1:0]   event_time;
        logic                last_in_run;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_evt_push;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_READ,
        SC_EVAL,
        SC_FLUSH
    } t_scan_state;

endpackage

FILE: rtl/core/switch_bank_debounce_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch bank debounce scanner
// Time-lockout debouncer for a bank of active-low switches.
//
// Each input word is one poll: expander pins, GPIO pins and a timestamp in ns.
// Only one poll in POLL_DIVIDE is evaluated; the others are accepted and
// only advance the poll counter. An evaluated poll visits every switch
// entry in the state memory in the read-modify-write sequencer, which
// reads the entry, then compares and writes it back. Input ready stays
// low for the scan. Each accepted change gives one output word, in
// ascending switch order, with last_in_run set on the final one of a poll.
// A word waits in the sequencer until the next accepted change is found or
// the scan ends, and then moves into the output register once it is free.
// A stalled receiver holds the scan at its next change until the output
// register frees up; nothing is dropped. Reset clears the poll counter,
// marks every switch released with change time zero, and loads the default
// debounce time. The configuration word may be written at any idle time.
// ----------------------------------------------------------------------------
module switch_bank_debounce_scanner_unit
    import sbds_pkg::*;
#(
    parameter int NUM_SWITCHES  = 18,
    parameter int EXPANDER_BITS = 16,
    parameter int POLL_DIVIDE   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_word        o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int PHASE_W = (POLL_DIVIDE > 1) ? $clog2(POLL_DIVIDE) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(POLL_DIVIDE - 1);

    logic [CFG_W-1:0]   r_debounce, n_debounce;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic      busy;
    logic      accept;
    logic      start;
    logic      out_free;
    t_evt_push push;

    assign o_ready     = !busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign start       = accept && (r_phase == '0);

    always_comb begin
        n_debounce = r_debounce;
        n_phase    = r_phase;
        if (i_cfg_valid) begin
            n_debounce = i_cfg_data;
        end
        if (accept) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_phase    <= '0;
        end else begin
            r_debounce <= n_debounce;
            r_phase    <= n_phase;
        end
    end

    sbds_scan #(
        .NUM_SWITCHES (NUM_SWITCHES),
        .EXPANDER_BITS(EXPANDER_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_word    (i_data),
        .i_debounce(r_debounce),
        .i_out_free(out_free),
        .o_busy    (busy),
        .o_push    (push)
    );

    sbds_outreg u_outreg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_free (out_free),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

endmodule

FILE: rtl/core/sbds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/sbds_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounce scan sequencer
// Walks the switch memory once per evaluated poll and emits accepted changes.
// ----------------------------------------------------------------------------
module sbds_scan
    import sbds_pkg::*;
#(
    parameter int NUM_SWITCHES  = 18,
    parameter int EXPANDER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_word         i_word,
    input  logic [CFG_W-1:0] i_debounce,
    input  logic             i_out_free,
    output logic             o_busy,
    output t_evt_push        o_push
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam int MEM_W = TIME_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SWITCHES - 1);

    t_scan_state             r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [NUM_SWITCHES-1:0] r_closed, n_closed;
    logic [TIME_W-1:0]       r_now, n_now;
    logic [NUM_SWITCHES-1:0] r_valid, n_valid;
    logic                    r_rd_ok, n_rd_ok;
    logic                    r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]        r_pend_idx, n_pend_idx;
    logic                    r_pend_level, n_pend_level;

    logic [NUM_SWITCHES-1:0] closed_now;
    logic                    rd_en;
    logic                    wr_en;
    logic [MEM_W-1:0]        rd_data;
    logic                    cur_level;
    logic [TIME_W-1:0]       stored_time;
    logic [TIME_W:0]         diff;
    logic                    new_level;
    logic                    accept_chg;
    logic [31:0]             pend_idx_wide;

    genvar g;
    generate
        for (g = 0; g < NUM_SWITCHES; g++) begin : g_src
            if (g < GPIO_SWITCHES) begin : g_gpio
                assign closed_now[g] = ~i_word.gpio_bits[g];
            end else if ((g - GPIO_SWITCHES) < EXPANDER_BITS &&
                         (g - GPIO_SWITCHES) < EXP_FIELD_W) begin : g_exp
                assign closed_now[g] = ~i_word.expander_word[g - GPIO_SWITCHES];
            end else begin : g_none
                assign closed_now[g] = 1'b0;
            end
        end
    endgenerate

    sbds_ram #(
        .WIDTH(MEM_W),
        .DEPTH(NUM_SWITCHES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_idx),
        .i_wr_data({new_level, r_now}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    assign cur_level     = r_rd_ok ? rd_data[MEM_W-1] : 1'b0;
    assign stored_time   = r_rd_ok ? rd_data[TIME_W-1:0] : '0;
    assign new_level     = r_closed[r_idx];
    assign diff          = {1'b0, r_now} - {1'b0, stored_time};
    assign accept_chg    = (new_level != cur_level) && !diff[TIME_W] &&
                           (diff[TIME_W-1:0] >= TIME_W'(i_debounce));
    assign pend_idx_wide = 32'(r_pend_idx);
    assign o_busy        = (r_state != SC_IDLE);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_closed     = r_closed;
        n_now        = r_now;
        n_valid      = r_valid;
        n_rd_ok      = r_rd_ok;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_level = r_pend_level;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        o_push.valid = 1'b0;
        o_push.word.switch_index = pend_idx_wide[SW_IDX_W-1:0];
        o_push.word.pressed      = r_pend_level;
        o_push.word.event_time   = r_now;
        o_push.word.last_in_run  = 1'b0;
        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_closed = closed_now;
                    n_now    = i_word.now_time;
                    n_idx    = '0;
                    n_state  = SC_READ;
                end
            end
            SC_READ: begin
                rd_en   = 1'b1;
                n_rd_ok = r_valid[r_idx];
                n_state = SC_EVAL;
            end
            SC_EVAL: begin
                if (!accept_chg || !r_pend_valid || i_out_free) begin
                    if (accept_chg) begin
                        wr_en          = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        o_push.valid   = r_pend_valid;
                        n_pend_valid   = 1'b1;
                        n_pend_idx     = r_idx;
                        n_pend_level   = new_level;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = SC_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = SC_READ;
                    end
                end
            end
            SC_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = SC_IDLE;
                end else if (i_out_free) begin
                    o_push.valid            = 1'b1;
                    o_push.word.last_in_run = 1'b1;
                    n_pend_valid            = 1'b0;
                    n_state                 = SC_IDLE;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SC_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_rd_ok      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_rd_ok      <= n_rd_ok;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_closed     <= n_closed;
        r_now        <= n_now;
        r_pend_idx   <= n_pend_idx;
        r_pend_level <= n_pend_level;
    end

endmodule

FILE: rtl/core/sbds_outreg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event output register
// Holds one event word for the receiver and reports when it can take another.
// ----------------------------------------------------------------------------
module sbds_outreg
    import sbds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_evt_push i_push,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic      r_valid, n_valid;
    t_out_word r_word, n_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (i_push.valid) begin
            n_valid = 1'b1;
            n_word  = i_push.word;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

FILE: verif/switch_bank_debounce_scanner_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch bank debounce scanner testbench
// Drives polls of the switch bank through the input word channel and writes
// the debounce time through the configuration channel. Every accepted poll is
// run through a local model of the poll divider and the per-switch lockout,
// and every output word is compared field by field with the oldest predicted
// event. Directed tests cover the reset state, the exact lockout threshold,
// zero and maximum debounce times, time going backwards and the top of the
// time range; random polls follow under three idling patterns.
// ----------------------------------------------------------------------------
module switch_bank_debounce_scanner_unit_test;
    import sbds_pkg::*;

    localparam int NUM_SW = 18;
    localparam int POLL_DIV = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_POLLS = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [NUM_SW-1:0] ALL_CLOSED = {NUM_SW{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_word i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_word o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int model_phase;
    logic [NUM_SW-1:0] model_level;
    logic [TIME_W-1:0] model_change_time [NUM_SW];
    logic [CFG_W-1:0] model_debounce;
    t_out_word pending_events [$];

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 70;
    logic [TIME_W-1:0] base_time;

    switch_bank_debounce_scanner_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic predict_switch_events(input t_in_word w);
        logic [NUM_SW-1:0] closed;
        longint elapsed;
        t_out_word ev;
        t_out_word held;
        bit have_held;
        bit evaluate;
        closed = {~w.expander_word, ~w.gpio_bits};
        evaluate = (model_phase == 0);
        model_phase = (model_phase + 1) % POLL_DIV;
        have_held = 1'b0;
        held = '0;
        if (evaluate) begin
            for (int s = 0; s < NUM_SW; s++) begin
                if (closed[s] != model_level[s]) begin
                    elapsed = $signed({1'b0, w.now_time}) -
                              $signed({1'b0, model_change_time[s]});
                    if (elapsed >= $signed({32'd0, model_debounce})) begin
                        model_level[s] = closed[s];
                        model_change_time[s] = w.now_time;
                        ev.switch_index = SW_IDX_W'(s);
                        ev.pressed = closed[s];
                        ev.event_time = w.now_time;
                        ev.last_in_run = 1'b0;
                        if (have_held) begin
                            pending_events.push_back(held);
                        end
                        held = ev;
                        have_held = 1'b1;
                    end
                end
            end
            if (have_held) begin
                held.last_in_run = 1'b1;
                pending_events.push_back(held);
            end
        end
    endtask

    always @(posedge i_clk) begin : event_checker
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected word: idx=%0d pressed=%0b time=%0d last=%0b",
                             o_data.switch_index, o_data.pressed, o_data.event_time,
                             o_data.last_in_run);
                end
            end else begin
                want = pending_events.pop_front();
                if (o_data.switch_index !== want.switch_index ||
                    o_data.pressed !== want.pressed ||
                    o_data.event_time !== want.event_time ||
                    o_data.last_in_run !== want.last_in_run) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected idx=%0d pressed=%0b time=%0d last=%0b",
                                 want.switch_index, want.pressed, want.event_time,
                                 want.last_in_run);
                        $display("          actual   idx=%0d pressed=%0b time=%0d last=%0b",
                                 o_data.switch_index, o_data.pressed, o_data.event_time,
                                 o_data.last_in_run);
                    end
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_poll(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predict_switch_events(w);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [CFG_W-1:0] value);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        model_debounce = value;
    endtask

    function automatic t_in_word poll_word(input logic [NUM_SW-1:0] closed,
                                           input logic [TIME_W-1:0] stamp);
        t_in_word w;
        w.gpio_bits = ~closed[GPIO_SWITCHES-1:0];
        w.expander_word = ~closed[NUM_SW-1:GPIO_SWITCHES];
        w.now_time = stamp;
        return w;
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic t_in_word random_word();
        return poll_word(NUM_SW'($urandom), random_time());
    endfunction

    task automatic align_to_scan();
        while (model_phase != 0) begin
            send_poll(random_word());
        end
    endtask

    task automatic scan_poll(input logic [NUM_SW-1:0] closed, input logic [TIME_W-1:0] stamp);
        align_to_scan();
        send_poll(poll_word(closed, stamp));
    endtask

    task automatic test_reset_state();
        scan_poll('0, '0);
        scan_poll(ALL_CLOSED, '0);
    endtask

    task automatic test_press_at_threshold();
        scan_poll(ALL_CLOSED, TIME_W'(DEBOUNCE_RESET));
    endtask

    task automatic test_lockout_window();
        scan_poll('0, TIME_W'(2 * DEBOUNCE_RESET - 1));
        scan_poll('0, TIME_W'(2 * DEBOUNCE_RESET));
    endtask

    task automatic test_zero_debounce();
        write_debounce('0);
        scan_poll(18'h15555, TIME_W'(2 * DEBOUNCE_RESET));
    endtask

    task automatic test_time_backwards();
        scan_poll(18'h2AAAA, TIME_W'(2 * DEBOUNCE_RESET - 1));
    endtask

    task automatic test_debounce_ceiling();
        write_debounce({CFG_W{1'b1}});
        scan_poll(18'h2AAAA, TIME_W'(2 * DEBOUNCE_RESET) + TIME_W'(32'hFFFF_FFFE));
        scan_poll(18'h2AAAA, TIME_W'(2 * DEBOUNCE_RESET) + TIME_W'(32'hFFFF_FFFF));
    endtask

    task automatic test_time_ceiling();
        write_debounce('0);
        scan_poll(model_level ^ {1'b1, {(NUM_SW-1){1'b0}}}, TIME_MAX);
    endtask

    task automatic test_random_polls(input int send_pct, input int recv_pct,
                                     input logic [CFG_W-1:0] debounce);
        int sent;
        logic [NUM_SW-1:0] closed;
        logic [TIME_W-1:0] stamp;
        write_debounce(debounce);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < RANDOM_POLLS) begin
            if (model_phase == 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: closed = NUM_SW'($urandom);
                    5, 6, 7: closed = model_level ^ NUM_SW'($urandom & $urandom & $urandom);
                    8: closed = ALL_CLOSED;
                    default: closed = '0;
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        base_time = base_time + model_debounce + $urandom_range(0, 1000);
                        stamp = base_time;
                    end
                    6, 7: begin
                        if (model_debounce != 0) begin
                            base_time = base_time + $urandom_range(0, model_debounce - 1);
                        end
                        stamp = base_time;
                    end
                    8: stamp = base_time - $urandom_range(1, 1000);
                    default: begin
                        base_time = base_time + model_debounce;
                        stamp = base_time;
                    end
                endcase
                send_poll(poll_word(closed, stamp));
            end else if ($urandom_range(4) != 0) begin
                send_poll(poll_word(NUM_SW'($urandom), base_time + $urandom_range(0, 999)));
            end else begin
                send_poll(random_word());
            end
            sent++;
        end
    endtask

    initial begin
        model_phase = 0;
        model_level = '0;
        model_debounce = DEBOUNCE_RESET;
        for (int s = 0; s < NUM_SW; s++) begin
            model_change_time[s] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_press_at_threshold();
        test_lockout_window();
        test_zero_debounce();
        test_time_backwards();
        test_debounce_ceiling();
        test_time_ceiling();

        base_time = TIME_W'(2 * DEBOUNCE_RESET) + TIME_W'(33'h1_0000_0000);
        test_random_polls(8, 70, CFG_W'($urandom_range(1, 5000)));
        test_random_polls(70, 8, DEBOUNCE_RESET);
        test_random_polls(0, 0, $urandom);

        wait_drain();
        if (fail_count == 0 && pending_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
